/* rtl/chhi_pkg.sv */
// shared types, constants and tables for the compass heading block
package chhi_pkg;

    // default build parameters
    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 7;

    // fixed formats
    localparam int MAG_W        = 24;  // input sample width
    localparam int EXT_W        = 26;  // running min / max width
    localparam int OFF_W        = 25;  // hard-iron offset width
    localparam int DIFF_W       = 26;  // offset-corrected sample width
    localparam int CORDIC_XW    = 28;  // cordic x / y width, room for the gain
    localparam int CORDIC_ZW    = 34;  // angle accumulator width
    localparam int TABLE_FRAC   = 24;  // angle table in 1/2^24 degree
    localparam int TABLE_LEN    = 24;
    localparam int IDX_W        = 5;
    localparam int ATAN_W       = 30;
    localparam int SMOOTH_EXTRA = 8;   // extra fraction bits of the low-pass
    localparam int HEADING_W    = 16;
    localparam int DECAY_W      = 16;
    localparam int SPAN_W       = 23;
    localparam int CFG_DATA_W   = 23;
    localparam int CFG_IDX_W    = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN   = 1'b1;

    // register reset values
    localparam logic [DECAY_W-1:0] DECAY_STEP_RST = 16'd13;
    localparam logic [SPAN_W-1:0]  MIN_SPAN_RST   = 23'd12800;

    // extreme limits
    localparam logic signed [EXT_W-1:0] EXT_HI = {1'b0, {(EXT_W-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] EXT_LO = {1'b1, {(EXT_W-1){1'b0}}};

    // 180 degrees in accumulator units
    localparam logic signed [CORDIC_ZW-1:0] Z_HALF_TURN = CORDIC_ZW'(180) << TABLE_FRAC;

    // divide-by-ten constant of the low-pass
    localparam logic [4:0] LP_DIVISOR = 5'd10;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXT,
        ST_SPAN,
        ST_PREP,
        ST_GO,
        ST_CORDIC,
        ST_ROUND,
        ST_FOLD,
        ST_NUM,
        ST_DIV,
        ST_OUT
    } chhi_state_t;

    // request into the cordic unit
    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
    } cordic_req_t;

    // response from the cordic unit
    typedef struct packed {
        logic                        done;
        logic signed [CORDIC_ZW-1:0] z;
    } cordic_rsp_t;

    // atan(2^-i) in 1/2^24 degree
    function automatic logic [ATAN_W-1:0] atan_rom(input logic [IDX_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp a one-bit-grown extreme back into its register range
    function automatic logic signed [EXT_W-1:0] sat_ext(input logic signed [EXT_W:0] v);
        logic signed [EXT_W-1:0] r;
        if (v[EXT_W] != v[EXT_W-1]) begin
            r = v[EXT_W] ? EXT_LO : EXT_HI;
        end else begin
            r = v[EXT_W-1:0];
        end
        return r;
    endfunction

    // clamp a midpoint into the offset range
    function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [OFF_W:0] v);
        logic signed [OFF_W-1:0] r;
        if (v[OFF_W] != v[OFF_W-1]) begin
            r = v[OFF_W] ? {1'b1, {(OFF_W-1){1'b0}}} : {1'b0, {(OFF_W-1){1'b1}}};
        end else begin
            r = v[OFF_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/chhi_cordic.sv */
// iterative vectoring cordic: one shift-add step per cycle
module chhi_cordic #(
    parameter int STEPS = chhi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  chhi_pkg::cordic_req_t req,
    output chhi_pkg::cordic_rsp_t rsp
);

    localparam int XW     = chhi_pkg::CORDIC_XW;
    localparam int ZW     = chhi_pkg::CORDIC_ZW;
    localparam int NSTEPS = (STEPS > chhi_pkg::TABLE_LEN) ? chhi_pkg::TABLE_LEN : STEPS;
    localparam int CW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
    localparam logic [CW-1:0] LAST = CW'(NSTEPS - 1);

    logic                 busy_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    logic [chhi_pkg::IDX_W-1:0] idx;
    logic signed [XW-1:0]       x_sh, y_sh, x_ld, x_next, y_next, y_ld;
    logic signed [ZW-1:0]       atan_z, z_next;
    logic                       rot_pos, in_neg;

    // shared shifter and adders of one step
    always_comb begin
        idx     = chhi_pkg::IDX_W'(cnt_reg);
        x_sh    = x_reg >>> idx;
        y_sh    = y_reg >>> idx;
        atan_z  = $signed(ZW'(chhi_pkg::atan_rom(idx)));
        rot_pos = !y_reg[XW-1] && (y_reg != '0);
        if (rot_pos) begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + atan_z;
        end else begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - atan_z;
        end
    end

    // vectors in the left half plane are turned by 180 degrees first
    always_comb begin
        in_neg = req.x[chhi_pkg::DIFF_W-1];
        x_ld   = in_neg ? -XW'(req.x) : XW'(req.x);
        y_ld   = in_neg ? -XW'(req.y) : XW'(req.y);
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // x, y and angle registers
    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg <= x_ld;
            y_reg <= y_ld;
            z_reg <= in_neg ? chhi_pkg::Z_HALF_TURN : '0;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign rsp.done = busy_reg && (cnt_reg == LAST);
    assign rsp.z    = z_reg;

endmodule

/* rtl/compass_heading_hard_iron_autocal.sv */
// compass heading with running hard-iron calibration, top level
//
// Input channel s_*: one horizontal magnetometer sample (s_mag_x, s_mag_y),
// signed, 1/128 count units, taken on s_valid && s_ready. Result channel m_*:
// smoothed heading in 1/2^FRACTION_BITS degree plus a flag telling whether
// the hard-iron offsets were refreshed by that item. Registers decay_step and
// min_span are written through cfg_wr_en / cfg_wr_index / cfg_wr_data.
//
// The block works on one item at a time: it takes no new item until the
// result of the last one is loaded into the output register. An item passes
// through min / max tracking, the span test, offset correction, the
// iterative cordic (one step a cycle), rounding, folding into one turn and
// the low-pass, whose divide by ten is a reciprocal multiply.
//
// The result sits in an output register, so the next item is taken while a
// result waits; if the receiver stalls long enough, the block holds its new
// result until the register frees up. Reset restores the register defaults,
// opens the min / max trackers, clears the offsets and the low-pass state.
module compass_heading_hard_iron_autocal #(
    parameter int CORDIC_STEPS  = chhi_pkg::CORDIC_STEPS_DEF,
    parameter int FRACTION_BITS = chhi_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [chhi_pkg::CFG_IDX_W-1:0]         cfg_wr_index,
    input  logic [chhi_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    // input items
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [chhi_pkg::MAG_W-1:0]      s_mag_x,
    input  logic signed [chhi_pkg::MAG_W-1:0]      s_mag_y,
    // result items
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [chhi_pkg::HEADING_W-1:0]         m_heading,
    output logic                                   m_offset_updated
);

    localparam int EW       = chhi_pkg::EXT_W;
    localparam int OW       = chhi_pkg::OFF_W;
    localparam int DW       = chhi_pkg::DIFF_W;
    localparam int ZW       = chhi_pkg::CORDIC_ZW;
    localparam int SE       = chhi_pkg::SMOOTH_EXTRA;
    localparam int ANG_FRAC = FRACTION_BITS + SE;
    localparam int RSH      = chhi_pkg::TABLE_FRAC - ANG_FRAC;
    localparam int RW       = ZW - RSH;
    localparam int SW       = $clog2(360) + ANG_FRAC;
    localparam int NW       = SW + 4;
    localparam int HW       = SW - SE + 1;
    localparam int QSH      = NW + 3;

    localparam logic [SW-1:0]        FULL     = SW'(360) << ANG_FRAC;
    localparam logic signed [RW-1:0] FULL_S   = $signed(RW'(FULL));
    localparam logic signed [ZW-1:0] RND_HALF = ZW'(1) << (RSH - 1);
    localparam logic [HW-1:0]        FULL_OUT = HW'(360) << FRACTION_BITS;
    // ceil(2^QSH / 10), exact floor quotient for every numerator below 2^NW
    localparam logic [NW-1:0]        RECIP    =
        NW'(((longint'(1) << QSH) + longint'(chhi_pkg::LP_DIVISOR) - 1) /
            longint'(chhi_pkg::LP_DIVISOR));

    chhi_pkg::chhi_state_t state_reg, state_next;

    // configuration registers
    logic [chhi_pkg::DECAY_W-1:0] decay_reg;
    logic [chhi_pkg::SPAN_W-1:0]  min_span_reg;

    // calibration state
    logic signed [EW-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [OW-1:0] offset_x_reg, offset_y_reg;
    logic [SW-1:0]        smooth_reg;

    // per-item working registers
    logic signed [chhi_pkg::MAG_W-1:0] x_reg, y_reg;
    logic signed [DW-1:0]              cx_reg, cy_reg;
    logic                              upd_reg;
    logic signed [RW-1:0]              r_reg;
    logic [SW-1:0]                     raw_reg;
    logic [NW-1:0]                     num_reg;

    // result register
    logic                            m_valid_reg;
    logic [chhi_pkg::HEADING_W-1:0]  m_heading_reg;
    logic                            m_upd_reg;

    chhi_pkg::cordic_req_t cordic_req;
    chhi_pkg::cordic_rsp_t cordic_rsp;

    logic out_free, out_load;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg    <= chhi_pkg::DECAY_STEP_RST;
            min_span_reg <= chhi_pkg::MIN_SPAN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                chhi_pkg::CFG_DECAY_STEP: decay_reg    <= cfg_wr_data[chhi_pkg::DECAY_W-1:0];
                chhi_pkg::CFG_MIN_SPAN:   min_span_reg <= cfg_wr_data[chhi_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // extremes: take the sample in, then relax inward by the decay
    logic signed [EW-1:0] xs, ys, lo_x, hi_x, lo_y, hi_y;
    logic signed [EW-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
    logic signed [EW:0]   dec_s;
    always_comb begin
        xs         = EW'(x_reg);
        ys         = EW'(y_reg);
        dec_s      = $signed((EW+1)'(decay_reg));
        lo_x       = (xs < min_x_reg) ? xs : min_x_reg;
        hi_x       = (xs > max_x_reg) ? xs : max_x_reg;
        lo_y       = (ys < min_y_reg) ? ys : min_y_reg;
        hi_y       = (ys > max_y_reg) ? ys : max_y_reg;
        min_x_next = chhi_pkg::sat_ext((EW+1)'(lo_x) + dec_s);
        max_x_next = chhi_pkg::sat_ext((EW+1)'(hi_x) - dec_s);
        min_y_next = chhi_pkg::sat_ext((EW+1)'(lo_y) + dec_s);
        max_y_next = chhi_pkg::sat_ext((EW+1)'(hi_y) - dec_s);
    end

    // span test and midpoints
    logic signed [EW:0]   ms_s, span_x, span_y, sum_x, sum_y;
    logic signed [OW-1:0] offset_x_next, offset_y_next;
    logic                 upd_next;
    always_comb begin
        ms_s          = $signed((EW+1)'(min_span_reg));
        span_x        = (EW+1)'(max_x_reg) - (EW+1)'(min_x_reg);
        span_y        = (EW+1)'(max_y_reg) - (EW+1)'(min_y_reg);
        sum_x         = (EW+1)'(max_x_reg) + (EW+1)'(min_x_reg);
        sum_y         = (EW+1)'(max_y_reg) + (EW+1)'(min_y_reg);
        upd_next      = (span_x > ms_s) && (span_y > ms_s);
        offset_x_next = chhi_pkg::sat_off(sum_x[EW:1]);
        offset_y_next = chhi_pkg::sat_off(sum_y[EW:1]);
    end

    // offset-corrected vector
    logic signed [DW-1:0] cx_next, cy_next;
    assign cx_next = DW'(x_reg) - DW'(offset_x_reg);
    assign cy_next = DW'(y_reg) - DW'(offset_y_reg);

    // round the angle to the low-pass resolution
    logic signed [ZW-1:0] z_rnd;
    logic signed [RW-1:0] r_next;
    always_comb begin
        z_rnd  = cordic_rsp.z + RND_HALF;
        r_next = $signed(z_rnd[ZW-1:RSH]);
    end

    // fold into one turn; a zero vector reads as north
    logic [SW-1:0] raw_next;
    always_comb begin
        if (cx_reg == '0 && cy_reg == '0) begin
            raw_next = '0;
        end else if (r_reg < 0) begin
            raw_next = SW'(r_reg + FULL_S);
        end else if (r_reg >= FULL_S) begin
            raw_next = SW'(r_reg - FULL_S);
        end else begin
            raw_next = SW'(r_reg);
        end
    end

    // low-pass numerator 9*s + raw + 5
    logic [NW-1:0] num_next;
    assign num_next = (NW'(smooth_reg) << 3) + NW'(smooth_reg) + NW'(raw_reg) + NW'(5);

    // divide by ten through a reciprocal multiply
    logic [2*NW-1:0] lp_prod;
    logic [SW-1:0]   lp_quot;
    always_comb begin
        lp_prod = (2*NW)'(num_reg) * (2*NW)'(RECIP);
        lp_quot = lp_prod[QSH +: SW];
    end

    // output rounding of the smoothed heading
    logic [SW:0]   h_sum;
    logic [HW-1:0] h_raw, h_fold;
    always_comb begin
        h_sum  = {1'b0, smooth_reg} + (SW+1)'(1 << (SE - 1));
        h_raw  = h_sum[SW:SE];
        h_fold = (h_raw >= FULL_OUT) ? h_raw - FULL_OUT : h_raw;
    end

    // shared cordic unit
    chhi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cordic_req),
        .rsp     (cordic_rsp)
    );

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            chhi_pkg::ST_IDLE:   if (s_valid) state_next = chhi_pkg::ST_EXT;
            chhi_pkg::ST_EXT:    state_next = chhi_pkg::ST_SPAN;
            chhi_pkg::ST_SPAN:   state_next = chhi_pkg::ST_PREP;
            chhi_pkg::ST_PREP:   state_next = chhi_pkg::ST_GO;
            chhi_pkg::ST_GO:     state_next = chhi_pkg::ST_CORDIC;
            chhi_pkg::ST_CORDIC: if (cordic_rsp.done) state_next = chhi_pkg::ST_ROUND;
            chhi_pkg::ST_ROUND:  state_next = chhi_pkg::ST_FOLD;
            chhi_pkg::ST_FOLD:   state_next = chhi_pkg::ST_NUM;
            chhi_pkg::ST_NUM:    state_next = chhi_pkg::ST_DIV;
            chhi_pkg::ST_DIV:    state_next = chhi_pkg::ST_OUT;
            chhi_pkg::ST_OUT:    if (out_free) state_next = chhi_pkg::ST_IDLE;
            default:             state_next = chhi_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready          = 1'b0;
        out_load         = 1'b0;
        cordic_req.start = 1'b0;
        cordic_req.x     = cx_reg;
        cordic_req.y     = cy_reg;
        case (state_reg)
            chhi_pkg::ST_IDLE: s_ready          = 1'b1;
            chhi_pkg::ST_GO:   cordic_req.start = 1'b1;
            chhi_pkg::ST_OUT:  out_load         = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chhi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // calibration and low-pass state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg    <= chhi_pkg::EXT_HI;
            min_y_reg    <= chhi_pkg::EXT_HI;
            max_x_reg    <= chhi_pkg::EXT_LO;
            max_y_reg    <= chhi_pkg::EXT_LO;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            smooth_reg   <= '0;
        end else begin
            case (state_reg)
                chhi_pkg::ST_EXT: begin
                    min_x_reg <= min_x_next;
                    max_x_reg <= max_x_next;
                    min_y_reg <= min_y_next;
                    max_y_reg <= max_y_next;
                end
                chhi_pkg::ST_SPAN: begin
                    if (upd_next) begin
                        offset_x_reg <= offset_x_next;
                        offset_y_reg <= offset_y_next;
                    end
                end
                chhi_pkg::ST_DIV: smooth_reg <= lp_quot;
                default: ;
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            chhi_pkg::ST_IDLE: begin
                x_reg <= s_mag_x;
                y_reg <= s_mag_y;
            end
            chhi_pkg::ST_SPAN:  upd_reg <= upd_next;
            chhi_pkg::ST_PREP: begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
            end
            // the cordic holds its final angle once its last step is taken
            chhi_pkg::ST_ROUND:  r_reg   <= r_next;
            chhi_pkg::ST_FOLD:   raw_reg <= raw_next;
            chhi_pkg::ST_NUM:    num_reg <= num_next;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_heading_reg <= chhi_pkg::HEADING_W'(h_fold);
            m_upd_reg     <= upd_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_heading        = m_heading_reg;
    assign m_offset_updated = m_upd_reg;

`ifndef SYNTH
    // one item at a time: no second item right after an accepted one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while previous item in flight");

    // cordic never finishes while the sequencer is idle
    a_cordic_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chhi_pkg::ST_IDLE) |-> !cordic_rsp.done)
        else $error("cordic done outside of its phase");

    // folded raw heading stays within one turn
    a_raw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chhi_pkg::ST_NUM) |-> (raw_reg < FULL))
        else $error("raw heading out of range");

    // smoothed heading stays within one turn
    a_smooth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        smooth_reg < FULL)
        else $error("smoothed heading out of range");
`endif

endmodule
